// ===== design/ssd_pkg.sv =====
package ssd_pkg;

	// Request codes on the cmd field
	localparam logic [1:0] CMD_SHOW   = 2'd1;
	localparam logic [1:0] CMD_BRIGHT = 2'd2;

	// Bytes sent to the display
	localparam logic [7:0] BYTE_DATA_SET = 8'h40;
	localparam logic [7:0] BYTE_ADDR_SET = 8'hC0;
	localparam logic [7:0] BYTE_DISP_CTL = 8'h88;
	localparam logic [7:0] SEG_BLANK     = 8'h00;

	localparam logic [2:0] BRIGHT_RESET = 3'd4;

	// Reciprocals for the digit split: q = (x * R) >> S
	localparam logic [13:0] RECIP_1000 = 14'd8389;   // shift 23, x < 2^14
	localparam logic [13:0] RECIP_100  = 14'd10486;  // shift 20, x < 2^14
	localparam logic [13:0] RECIP_10W  = 14'd6554;   // shift 16, x < 2^14
	localparam logic [7:0]  RECIP_10N  = 8'd205;     // shift 11, x < 256

	// Queue between the digit front end and the sequencer
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef enum logic [1:0] {
		REQ_TICK,
		REQ_SHOW,
		REQ_BRIGHT
	} req_t;

	// Pin sequence phases, in order of a frame
	typedef enum logic [2:0] {
		PH_START,
		PH_BIT_LO,
		PH_BIT_HI,
		PH_ACK_LO,
		PH_ACK_HI,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C
	} phase_t;

	// One classified item: request and the four segment codes
	typedef struct packed {
		req_t             req;
		logic [3:0][7:0]  segs;
	} item_t;

	// Decimal digit to segment pattern
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		unique case (digit)
			4'd0:    code = 8'h3F;
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h5B;
			4'd3:    code = 8'h4F;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'h6D;
			4'd6:    code = 8'h7D;
			4'd7:    code = 8'h07;
			4'd8:    code = 8'h7F;
			4'd9:    code = 8'h6F;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// ===== design/seven_segment_serial_display_driver.sv =====
// Two-wire serial driver for a four-digit seven-segment LED display.
// Every input item is one half-bit tick and gives exactly one result item
// with the clock pin level, data pin level, data pin drive enable, a busy
// flag and whether the item's request was taken.
// cmd 1 shows value (leading zeros blanked), cmd 2 sends the brightness
// control byte; any request that arrives while a sequence runs is dropped.
// Brightness is written through cfg_we/cfg_wdata; the user must do so only
// while idle; the block does not enforce it. Channels: in_valid/in_ready
// and out_valid/out_ready. An item passes three digit split stages, one
// queue slot and the sequencer's output register. Throughput: one item per
// cycle while out_ready holds; the front end and the pin sequencer each
// take one item a cycle and the two-entry queue between them absorbs stalls.
// A stalled receiver holds the output register, then fills the queue, then
// stalls the whole front once stage 3 holds an item; then in_ready falls.
// Reset: pins idle high, no sequence active, brightness 4, queue empty.
module seven_segment_serial_display_driver (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   cmd,
	input  logic [13:0]  value,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         clk_level,
	output logic         dio_level,
	output logic         dio_drive,
	output logic         busy_res,
	output logic         accepted
);

	logic            f_valid, f_ready;
	ssd_pkg::item_t  f_item;
	logic            b_valid, b_ready;
	ssd_pkg::item_t  b_item;

	ssd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.value      (value),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	ssd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	ssd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.clk_level  (clk_level),
		.dio_level  (dio_level),
		.dio_drive  (dio_drive),
		.busy_res   (busy_res),
		.accepted   (accepted)
	);

`ifndef SYNTHESIS
	// A released data pin always reads at the pull-up level
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dio_drive |-> dio_level)
		else $error("released data pin not high");

	// A taken request starts a sequence on the same tick
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> busy_res && clk_level && !dio_level)
		else $error("accepted item without start condition");

	// Between sequences both lines rest high and driven
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> clk_level && dio_level && dio_drive)
		else $error("idle lines not high");
`endif

endmodule

// ===== design/ssd_front.sv =====
module ssd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [13:0]        value,
	output logic               item_valid,
	input  logic               item_ready,
	output ssd_pkg::item_t     item
);

	logic adv;

	// Stage 1: request decode and the three quotients of the value
	logic               v_s1;
	ssd_pkg::req_t      req_s1;
	logic [13:0]        value_s1;
	logic               ge1000_s1, ge100_s1, ge10_s1;
	logic [4:0]         q1000_s1;
	logic [7:0]         q100_s1;
	logic [10:0]        q10_s1;

	// Stage 2: digits from the quotients
	logic               v_s2;
	ssd_pkg::req_t      req_s2;
	logic               ge1000_s2, ge100_s2, ge10_s2;
	logic [3:0]         d0_s2, d3_s2;
	logic [7:0]         q100_s2;
	logic [4:0]         t100_s2;
	logic [10:0]        q10_s2;
	logic [7:0]         t10_s2;

	// Stage 3: segment codes, handed to the queue
	logic               v_s3;
	ssd_pkg::item_t     item_s3;

	ssd_pkg::req_t      req_c;
	logic [27:0]        p1000_c, p100_c, p10_c;
	logic [13:0]        ten_q10_c;
	logic [4:0]         d0_c;
	logic [15:0]        pt100_c;
	logic [23:0]        pt10_c;
	logic [7:0]         d1_full_c;
	logic [10:0]        d2_full_c;
	ssd_pkg::item_t     item_c;

	// The whole front stalls together when stage 3 holds an item and the queue is full
	assign adv      = !v_s3 || item_ready;
	assign in_ready = adv;

	// Stage 1 logic
	always_comb begin
		if (cmd == ssd_pkg::CMD_SHOW) begin
			req_c = ssd_pkg::REQ_SHOW;
		end else if (cmd == ssd_pkg::CMD_BRIGHT) begin
			req_c = ssd_pkg::REQ_BRIGHT;
		end else begin
			req_c = ssd_pkg::REQ_TICK;
		end
		p1000_c = 28'(value) * 28'(ssd_pkg::RECIP_1000);
		p100_c  = 28'(value) * 28'(ssd_pkg::RECIP_100);
		p10_c   = 28'(value) * 28'(ssd_pkg::RECIP_10W);
	end

	// Stage 2 logic
	always_comb begin
		ten_q10_c = (14'(q10_s1) << 3) + (14'(q10_s1) << 1);
		d0_c      = (q1000_s1 >= 5'd10) ? (q1000_s1 - 5'd10) : q1000_s1;
		pt100_c   = 16'(q100_s1) * 16'(ssd_pkg::RECIP_10N);
		pt10_c    = 24'(q10_s1) * 24'(ssd_pkg::RECIP_10W);
	end

	// Stage 3 logic: remaining digits, table lookup and blanking
	always_comb begin
		d1_full_c = q100_s2 - ((8'(t100_s2) << 3) + (8'(t100_s2) << 1));
		d2_full_c = q10_s2 - ((11'(t10_s2) << 3) + (11'(t10_s2) << 1));
		item_c.req     = req_s2;
		item_c.segs[0] = ge1000_s2 ? ssd_pkg::seg_code(d0_s2) : ssd_pkg::SEG_BLANK;
		item_c.segs[1] = ge100_s2 ? ssd_pkg::seg_code(d1_full_c[3:0]) : ssd_pkg::SEG_BLANK;
		item_c.segs[2] = ge10_s2 ? ssd_pkg::seg_code(d2_full_c[3:0]) : ssd_pkg::SEG_BLANK;
		item_c.segs[3] = ssd_pkg::seg_code(d3_s2);
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1    <= req_c;
			value_s1  <= value;
			ge1000_s1 <= value >= 14'd1000;
			ge100_s1  <= value >= 14'd100;
			ge10_s1   <= value >= 14'd10;
			q1000_s1  <= p1000_c[27:23];
			q100_s1   <= p100_c[27:20];
			q10_s1    <= p10_c[26:16];

			req_s2    <= req_s1;
			ge1000_s2 <= ge1000_s1;
			ge100_s2  <= ge100_s1;
			ge10_s2   <= ge10_s1;
			d0_s2     <= d0_c[3:0];
			d3_s2     <= 4'(value_s1 - ten_q10_c);
			q100_s2   <= q100_s1;
			t100_s2   <= pt100_c[15:11];
			q10_s2    <= q10_s1;
			t10_s2    <= pt10_c[23:16];

			item_s3   <= item_c;
		end
	end

	assign item_valid = v_s3;
	assign item       = item_s3;

endmodule

// ===== design/ssd_queue.sv =====
module ssd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ssd_pkg::item_t     push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ssd_pkg::item_t     pop_item
);

	ssd_pkg::item_t                mem_q [ssd_pkg::QUEUE_DEPTH];
	logic [ssd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [ssd_pkg::QPTR_W:0]      count_q;
	logic                          push, pop;

	assign push_ready = count_q != (ssd_pkg::QPTR_W + 1)'(ssd_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== design/ssd_back.sv =====
module ssd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata,
	input  logic               item_valid,
	output logic               item_ready,
	input  ssd_pkg::item_t     item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               clk_level,
	output logic               dio_level,
	output logic               dio_drive,
	output logic               busy_res,
	output logic               accepted
);

	// Sequencer state
	logic [2:0]          bright_q;
	logic                active_q;
	logic                job_show_q;
	logic [1:0]          frame_q;
	logic [2:0]          byte_q;
	logic [2:0]          bit_q;
	ssd_pkg::phase_t     phase_q;
	logic [7:0]          shift_q;
	logic [3:0][7:0]     segs_q;
	logic [1:0]          pins_q;

	// Output register
	logic                out_valid_q;
	logic                clk_level_q, dio_level_q, dio_drive_q, busy_q, accepted_q;

	logic                take, acc;
	logic                cur_active, cur_show;
	logic [1:0]          cur_frame;
	logic [2:0]          cur_byte, cur_bit;
	ssd_pkg::phase_t     cur_phase;
	logic [2:0]          nb;
	logic [2:0]          fbytes;

	logic                clk_c, dio_c, drive_c;
	logic                active_d, show_d;
	logic [1:0]          frame_d;
	logic [2:0]          byte_d, bit_d;
	ssd_pkg::phase_t     phase_d;
	logic [7:0]          shift_d;
	logic [1:0]          pins_d;

	// Byte to send at position idx of the current frame
	function automatic logic [7:0] frame_byte(
		input logic [1:0]       frame,
		input logic [2:0]       idx,
		input logic             show,
		input logic [2:0]       bright,
		input logic [3:0][7:0]  segs
	);
		logic [2:0] sel;
		logic [7:0] b;
		sel = idx - 3'd1;
		if (frame == 2'd0) begin
			b = show ? ssd_pkg::BYTE_DATA_SET : (ssd_pkg::BYTE_DISP_CTL | {5'd0, bright});
		end else if (idx == 3'd0) begin
			b = ssd_pkg::BYTE_ADDR_SET;
		end else begin
			b = segs[sel[1:0]];
		end
		return b;
	endfunction

	assign take       = item_valid && (!out_valid_q || out_ready);
	assign item_ready = !out_valid_q || out_ready;
	assign acc        = !active_q && (item.req == ssd_pkg::REQ_SHOW ||
	                                  item.req == ssd_pkg::REQ_BRIGHT);

	// State seen by this tick, after a possible new request
	always_comb begin
		cur_active = active_q || acc;
		cur_show   = acc ? (item.req == ssd_pkg::REQ_SHOW) : job_show_q;
		cur_frame  = acc ? 2'd0 : frame_q;
		cur_byte   = acc ? 3'd0 : byte_q;
		cur_bit    = acc ? 3'd0 : bit_q;
		cur_phase  = acc ? ssd_pkg::PH_START : phase_q;
		nb         = cur_byte + 3'd1;
		fbytes     = (cur_show && cur_frame == 2'd1) ? 3'd5 : 3'd1;
	end

	// Pin levels for this tick and the next sequencer state
	always_comb begin
		clk_c    = pins_q[1];
		dio_c    = pins_q[0];
		drive_c  = 1'b1;
		active_d = cur_active;
		show_d   = cur_show;
		frame_d  = cur_frame;
		byte_d   = cur_byte;
		bit_d    = cur_bit;
		phase_d  = cur_phase;
		shift_d  = shift_q;
		pins_d   = pins_q;
		if (cur_active) begin
			unique case (cur_phase)
				ssd_pkg::PH_START: begin
					clk_c   = 1'b1;
					dio_c   = 1'b0;
					byte_d  = 3'd0;
					bit_d   = 3'd0;
					shift_d = frame_byte(cur_frame, 3'd0, cur_show, bright_q, segs_q);
					phase_d = ssd_pkg::PH_BIT_LO;
				end
				ssd_pkg::PH_BIT_LO: begin
					clk_c   = 1'b0;
					dio_c   = shift_q[0];
					phase_d = ssd_pkg::PH_BIT_HI;
				end
				ssd_pkg::PH_BIT_HI: begin
					clk_c   = 1'b1;
					dio_c   = shift_q[0];
					shift_d = shift_q >> 1;
					if (cur_bit == 3'd7) begin
						phase_d = ssd_pkg::PH_ACK_LO;
					end else begin
						bit_d   = cur_bit + 3'd1;
						phase_d = ssd_pkg::PH_BIT_LO;
					end
				end
				ssd_pkg::PH_ACK_LO: begin
					clk_c   = 1'b0;
					dio_c   = 1'b1;
					drive_c = 1'b0;
					phase_d = ssd_pkg::PH_ACK_HI;
				end
				ssd_pkg::PH_ACK_HI: begin
					clk_c   = 1'b1;
					dio_c   = 1'b1;
					drive_c = 1'b0;
					byte_d  = nb;
					if (nb < fbytes) begin
						bit_d   = 3'd0;
						shift_d = frame_byte(cur_frame, nb, cur_show, bright_q, segs_q);
						phase_d = ssd_pkg::PH_BIT_LO;
					end else begin
						phase_d = ssd_pkg::PH_STOP_A;
					end
				end
				ssd_pkg::PH_STOP_A: begin
					clk_c   = 1'b0;
					dio_c   = 1'b0;
					phase_d = ssd_pkg::PH_STOP_B;
				end
				ssd_pkg::PH_STOP_B: begin
					clk_c   = 1'b1;
					dio_c   = 1'b0;
					phase_d = ssd_pkg::PH_STOP_C;
				end
				ssd_pkg::PH_STOP_C: begin
					clk_c = 1'b1;
					dio_c = 1'b1;
					// show job goes on to its address frame
					if (cur_show && cur_frame == 2'd0) begin
						frame_d = 2'd1;
					end else begin
						active_d = 1'b0;
						frame_d  = 2'd0;
					end
					byte_d  = 3'd0;
					bit_d   = 3'd0;
					phase_d = ssd_pkg::PH_START;
				end
				default: begin
					phase_d = ssd_pkg::PH_START;
				end
			endcase
			pins_d = {clk_c, dio_c};
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q    <= ssd_pkg::BRIGHT_RESET;
			active_q    <= 1'b0;
			job_show_q  <= 1'b0;
			frame_q     <= 2'd0;
			byte_q      <= 3'd0;
			bit_q       <= 3'd0;
			phase_q     <= ssd_pkg::PH_START;
			shift_q     <= 8'd0;
			pins_q      <= 2'b11;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bright_q <= cfg_wdata;
			end
			if (take) begin
				active_q    <= active_d;
				job_show_q  <= show_d;
				frame_q     <= frame_d;
				byte_q      <= byte_d;
				bit_q       <= bit_d;
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				pins_q      <= pins_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Segment store and result payload
	always_ff @(posedge clk) begin
		if (take && acc && item.req == ssd_pkg::REQ_SHOW) begin
			segs_q <= item.segs;
		end
		if (take) begin
			clk_level_q <= clk_c;
			dio_level_q <= dio_c;
			dio_drive_q <= drive_c;
			busy_q      <= cur_active;
			accepted_q  <= acc;
		end
	end

	assign out_valid = out_valid_q;
	assign clk_level = clk_level_q;
	assign dio_level = dio_level_q;
	assign dio_drive = dio_drive_q;
	assign busy_res  = busy_q;
	assign accepted  = accepted_q;

endmodule
